// ===== design/abr_pkg.sv =====
// Shared constants, types and helpers for the audio byte ring.
package abr_pkg;

  localparam int RING_DEPTH = 16384;
  localparam int PTR_LIMIT  = 16384;
  localparam int PTR_W      = 14;
  localparam int CAP_W      = 15;
  localparam int CNT_W      = 32;
  localparam int DATA_W     = 8;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int EFF_MAX    = (RING_DEPTH < PTR_LIMIT) ? RING_DEPTH : PTR_LIMIT;
  localparam int OUT_TDATA_W = 152;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16384);

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef struct packed {
    logic             from_ring;
    logic [PTR_W-1:0] used_bytes;
    logic [CNT_W-1:0] overrun_total;
    logic [CNT_W-1:0] underrun_total;
    logic [CNT_W-1:0] write_packets;
    logic [CNT_W-1:0] read_packets;
  } result_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p,
                                            input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] n;
    n = {1'b0, p} + CAP_W'(1);
    return (n >= cap) ? '0 : n[PTR_W-1:0];
  endfunction

endpackage

// ===== design/abr_ram.sv =====
// Simple dual-port byte store (separate write and read ports) with registered, enabled read data.
module abr_ram #(
  parameter int DEPTH  = 16384,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/abr_ctrl.sv =====
// Ring pointers, packet flags and counters; one item handled per transfer.
module abr_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [abr_pkg::CAP_W-1:0]    cfg_data,
  input  logic                         accept,
  input  logic [1:0]                   action,
  input  logic [abr_pkg::DATA_W-1:0]   write_data,
  input  logic                         packet_last,
  output abr_pkg::result_t             result,
  output abr_pkg::ram_req_t            ram_req
);

  logic [abr_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic [abr_pkg::PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [abr_pkg::CNT_W-1:0] ovr_r, ovr_nxt, und_r, und_nxt;
  logic [abr_pkg::CNT_W-1:0] wpk_r, wpk_nxt, rpk_r, rpk_nxt;
  logic wdrop_r, wdrop_nxt, rshort_r, rshort_nxt, rgot_r, rgot_nxt;

  logic [abr_pkg::CAP_W-1:0] cap_eff;
  logic [abr_pkg::PTR_W-1:0] used, used_after;
  logic                      full;
  logic                      from;

  assign cap_eff = (cap_r > abr_pkg::CAP_W'(abr_pkg::EFF_MAX)) ?
                   abr_pkg::CAP_W'(abr_pkg::EFF_MAX) : cap_r;

  always_comb begin
    if (cap_eff == '0) begin
      used = '0;
    end else if (wp_r >= rp_r) begin
      used = wp_r - rp_r;
    end else begin
      used = abr_pkg::PTR_W'(cap_eff - {1'b0, rp_r} + {1'b0, wp_r});
    end
  end

  assign full = ({1'b0, used} + abr_pkg::CAP_W'(1)) >= cap_eff;

  always_comb begin
    cap_nxt    = cap_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    ovr_nxt    = ovr_r;
    und_nxt    = und_r;
    wpk_nxt    = wpk_r;
    rpk_nxt    = rpk_r;
    wdrop_nxt  = wdrop_r;
    rshort_nxt = rshort_r;
    rgot_nxt   = rgot_r;
    used_after = used;
    from       = 1'b0;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = abr_pkg::ADDR_W'(wp_r);
    ram_req.wr_data = write_data;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = abr_pkg::ADDR_W'(rp_r);
    if (cfg_we) begin
      cap_nxt    = cfg_data;
      wp_nxt     = '0;
      rp_nxt     = '0;
      wdrop_nxt  = 1'b0;
      rshort_nxt = 1'b0;
      rgot_nxt   = 1'b0;
    end else if (accept) begin
      case (action)
        abr_pkg::ACT_CLEAR: begin
          wp_nxt     = '0;
          rp_nxt     = '0;
          ovr_nxt    = '0;
          und_nxt    = '0;
          wpk_nxt    = '0;
          rpk_nxt    = '0;
          wdrop_nxt  = 1'b0;
          rshort_nxt = 1'b0;
          rgot_nxt   = 1'b0;
          used_after = '0;
        end
        abr_pkg::ACT_WRITE: begin
          if (cap_eff != '0) begin
            if (full) begin
              rp_nxt    = abr_pkg::bump(rp_r, cap_eff);
              wdrop_nxt = 1'b1;
            end else begin
              used_after = used + abr_pkg::PTR_W'(1);
            end
            ram_req.wr_en = 1'b1;
            wp_nxt = abr_pkg::bump(wp_r, cap_eff);
            if (packet_last) begin
              if (wdrop_nxt) begin
                ovr_nxt = ovr_r + abr_pkg::CNT_W'(1);
              end
              wpk_nxt   = wpk_r + abr_pkg::CNT_W'(1);
              wdrop_nxt = 1'b0;
            end
          end
        end
        abr_pkg::ACT_READ: begin
          if (cap_eff != '0) begin
            if (used != '0) begin
              ram_req.rd_en = 1'b1;
              from       = 1'b1;
              rp_nxt     = abr_pkg::bump(rp_r, cap_eff);
              rgot_nxt   = 1'b1;
              used_after = used - abr_pkg::PTR_W'(1);
            end else begin
              rshort_nxt = 1'b1;
            end
            if (packet_last) begin
              if (rshort_nxt) begin
                und_nxt = und_r + abr_pkg::CNT_W'(1);
              end
              if (rgot_nxt) begin
                rpk_nxt = rpk_r + abr_pkg::CNT_W'(1);
              end
              rshort_nxt = 1'b0;
              rgot_nxt   = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.from_ring      = from;
    result.used_bytes     = used_after;
    result.overrun_total  = ovr_nxt;
    result.underrun_total = und_nxt;
    result.write_packets  = wpk_nxt;
    result.read_packets   = rpk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= abr_pkg::CAP_RESET;
      wp_r     <= '0;
      rp_r     <= '0;
      ovr_r    <= '0;
      und_r    <= '0;
      wpk_r    <= '0;
      rpk_r    <= '0;
      wdrop_r  <= 1'b0;
      rshort_r <= 1'b0;
      rgot_r   <= 1'b0;
    end else begin
      cap_r    <= cap_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      ovr_r    <= ovr_nxt;
      und_r    <= und_nxt;
      wpk_r    <= wpk_nxt;
      rpk_r    <= rpk_nxt;
      wdrop_r  <= wdrop_nxt;
      rshort_r <= rshort_nxt;
      rgot_r   <= rgot_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_eff == '0) || ({1'b0, wp_r} < cap_eff && {1'b0, rp_r} < cap_eff))
    else $error("ring pointer beyond capacity");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg_we && action == abr_pkg::ACT_CLEAR) |=>
      (ovr_r == '0 && und_r == '0 && wpk_r == '0 && rpk_r == '0 && wp_r == rp_r))
    else $error("clear left state behind");
`endif

endmodule

// ===== design/abr_pipe.sv =====
// Result stage holding the RAM read data, plus output register.
module abr_pipe (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  abr_pkg::result_t                   result,
  input  logic [abr_pkg::DATA_W-1:0]         ram_q,
  output logic                               load_ready,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [abr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tuser
);

  abr_pkg::result_t          s1_res_r, out_res_r;
  logic [abr_pkg::DATA_W-1:0] out_data_r, s1_data;
  logic s1_v_r, s1_v_nxt, out_v_r, out_v_nxt;
  logic s1_adv;

  assign s1_adv     = s1_v_r && (!out_v_r || out_tready);
  assign load_ready = !s1_v_r || s1_adv;
  assign s1_data    = s1_res_r.from_ring ? ram_q : '0;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (load) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_res_r <= result;
    end
    if (s1_adv) begin
      out_res_r  <= s1_res_r;
      out_data_r <= s1_data;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.from_ring;
  assign out_tdata  = {2'b00,
                       out_res_r.read_packets,
                       out_res_r.write_packets,
                       out_res_r.underrun_total,
                       out_res_r.overrun_total,
                       out_res_r.used_bytes,
                       out_data_r};

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> (s1_v_r && $stable(s1_res_r)))
    else $error("stalled result stage changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!s1_v_r || s1_adv))
    else $error("result stage loaded while full");
`endif

endmodule

// ===== design/audio_byte_ring_overwrite_oldest_unit.sv =====
// A result passes through the result stage holding the RAM read, then the
// output register, before it is offered.
// Throughput: one item per cycle while out_tready is high; the byte RAM takes
// one access per item with registered read data. Two results wait before
// in_tready drops.
// Reset: pointers, packet flags and counters clear, capacity returns to 16384;
// the byte store is not cleared and needs no clearing pass.
module audio_byte_ring_overwrite_oldest_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [abr_pkg::CAP_W-1:0]       cfg_data,    // capacity_bytes
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,    // write_data
  input  logic [1:0]                      in_tuser,    // action
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // read_data[7:0], used_bytes[21:8], overrun_total[53:22],
  // underrun_total[85:54], write_packets[117:86], read_packets[149:118]
  output logic [abr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser    // from_ring
);

  abr_pkg::result_t           result;
  abr_pkg::ram_req_t          ram_req;
  logic [abr_pkg::DATA_W-1:0] ram_q;
  logic                       accept;
  logic                       cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;
  assign accept    = in_tvalid && in_tready;

  abr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .action      (in_tuser),
    .write_data  (in_tdata),
    .packet_last (in_tlast),
    .result      (result),
    .ram_req     (ram_req)
  );

  abr_ram #(
    .DEPTH (abr_pkg::RING_DEPTH),
    .WIDTH (abr_pkg::DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_q)
  );

  abr_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .result     (result),
    .ram_q      (ram_q),
    .load_ready (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== dv/tb_audio_byte_ring_overwrite_oldest_unit.sv =====
// Stream testbench for the audio byte ring: a ring predictor checks every result field.
module tb_audio_byte_ring_overwrite_oldest_unit;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0] action;
    logic [7:0] data;
    logic       is_last;
  } ring_op_t;

  typedef struct {
    logic [7:0]  read_data;
    logic        from_ring;
    logic [13:0] used_bytes;
    logic [31:0] overrun_total;
    logic [31:0] underrun_total;
    logic [31:0] write_packets;
    logic [31:0] read_packets;
  } ring_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [abr_pkg::CAP_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [abr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;

  audio_byte_ring_overwrite_oldest_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // predicted ring state
  logic [7:0] ring_bytes [abr_pkg::RING_DEPTH];
  logic [abr_pkg::CAP_W-1:0] cap_reg = abr_pkg::CAP_RESET;
  int wr_ptr = 0;
  int rd_ptr = 0;
  logic [31:0] overruns = '0;
  logic [31:0] underruns = '0;
  logic [31:0] wr_pkts = '0;
  logic [31:0] rd_pkts = '0;
  bit dropped = 1'b0;
  bit short_read = 1'b0;
  bit got_data = 1'b0;

  ring_op_t ops_pending[$];
  ring_status_t status_due[$];
  ring_op_t bus_op;

  int idle_pct = 0;
  int send_gap = 0;
  int stall_left = 0;
  int mismatches = 0;
  int ops_sent = 0;
  int results_seen = 0;
  int cap_writes = 0;
  int overrun_events = 0;
  int underrun_events = 0;
  int cycles = 0;

  function automatic int eff_cap();
    return (int'(cap_reg) > abr_pkg::EFF_MAX) ? abr_pkg::EFF_MAX : int'(cap_reg);
  endfunction

  function automatic int step_ptr(input int p, input int cap);
    return (p + 1 >= cap) ? 0 : p + 1;
  endfunction

  function automatic int ring_fill(input int cap);
    if (cap == 0) return 0;
    return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : cap - (rd_ptr - wr_ptr);
  endfunction

  task automatic advance_ring(input ring_op_t op);
    ring_status_t s;
    int cap;
    cap = eff_cap();
    s.read_data = '0;
    s.from_ring = 1'b0;
    if (op.action == abr_pkg::ACT_CLEAR) begin
      wr_ptr = 0;
      rd_ptr = 0;
      dropped = 0;
      short_read = 0;
      got_data = 0;
      overruns = '0;
      underruns = '0;
      wr_pkts = '0;
      rd_pkts = '0;
    end else if (op.action == abr_pkg::ACT_WRITE && cap != 0) begin
      if (ring_fill(cap) + 1 >= cap) begin
        rd_ptr = step_ptr(rd_ptr, cap);
        dropped = 1;
      end
      ring_bytes[wr_ptr] = op.data;
      wr_ptr = step_ptr(wr_ptr, cap);
      if (op.is_last) begin
        if (dropped) begin
          overruns++;
          overrun_events++;
        end
        wr_pkts++;
        dropped = 0;
      end
    end else if (op.action == abr_pkg::ACT_READ && cap != 0) begin
      if (ring_fill(cap) != 0) begin
        s.read_data = ring_bytes[rd_ptr];
        s.from_ring = 1'b1;
        rd_ptr = step_ptr(rd_ptr, cap);
        got_data = 1;
      end else begin
        short_read = 1;
      end
      if (op.is_last) begin
        if (short_read) begin
          underruns++;
          underrun_events++;
        end
        if (got_data) rd_pkts++;
        short_read = 0;
        got_data = 0;
      end
    end
    s.used_bytes = 14'(ring_fill(cap));
    s.overrun_total = overruns;
    s.underrun_total = underruns;
    s.write_packets = wr_pkts;
    s.read_packets = rd_pkts;
    status_due.push_back(s);
  endtask

  // input side: one item per transfer, prediction made at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_ring(bus_op);
        ops_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (ops_pending.size() != 0) begin
          bus_op = ops_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= bus_op.action;
          in_tdata <= bus_op.data;
          in_tlast <= bus_op.is_last;
          if ($urandom_range(0, 99) < idle_pct) send_gap = $urandom_range(1, 15);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result side
  always @(posedge clk) begin
    ring_status_t s;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (status_due.size() == 0) begin
          $error("result transfer with no expectation pending");
          mismatches++;
        end else begin
          s = status_due.pop_front();
          check_field("read_data", 32'(s.read_data), 32'(out_tdata[7:0]));
          check_field("from_ring", 32'(s.from_ring), 32'(out_tuser));
          check_field("used_bytes", 32'(s.used_bytes), 32'(out_tdata[21:8]));
          check_field("overrun_total", s.overrun_total, out_tdata[53:22]);
          check_field("underrun_total", s.underrun_total, out_tdata[85:54]);
          check_field("write_packets", s.write_packets, out_tdata[117:86]);
          check_field("read_packets", s.read_packets, out_tdata[149:118]);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 14);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_op(input logic [1:0] a, input logic [7:0] d, input logic l);
    ring_op_t op;
    op.action = a;
    op.data = d;
    op.is_last = l;
    ops_pending.push_back(op);
  endtask

  task automatic drain();
    @(posedge clk);
    while (ops_pending.size() != 0 || in_tvalid || status_due.size() != 0)
      @(posedge clk);
  endtask

  // only called with the ring idle
  task automatic load_capacity(input logic [abr_pkg::CAP_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_reg = v;
    wr_ptr = 0;
    rd_ptr = 0;
    dropped = 0;
    short_read = 0;
    got_data = 0;
    cap_writes++;
  endtask

  // packets of random length, occasional clears and stray items
  task automatic queue_traffic(input int n);
    int pick, len, k;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      if (pick < 88) begin
        for (int j = 0; j < len; j++)
          queue_op((pick < 44) ? abr_pkg::ACT_WRITE : abr_pkg::ACT_READ,
                   8'($urandom_range(0, 255)), j == len - 1);
        k += len;
      end else begin
        if (pick < 96) len = $urandom_range(0, 1);
        else if (pick < 98) len = abr_pkg::ACT_CLEAR;
        else len = ACT_UNUSED;
        queue_op(2'(len), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        k++;
      end
    end
  endtask

  initial begin
    int phase_caps[$];
    phase_caps = '{3, 16, 1, 64, 0, 7, 2, 255, 16384, 32767, 16385, 5, 4096};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset capacity, empty read, packet spanning data and padding
    queue_op(abr_pkg::ACT_READ, 8'h00, 1'b1);
    queue_op(abr_pkg::ACT_WRITE, 8'h00, 1'b0);
    queue_op(abr_pkg::ACT_WRITE, 8'hFF, 1'b1);
    queue_op(ACT_UNUSED, 8'hAA, 1'b1);
    queue_op(abr_pkg::ACT_READ, 8'h55, 1'b0);
    queue_op(abr_pkg::ACT_READ, 8'h00, 1'b0);
    queue_op(abr_pkg::ACT_READ, 8'h00, 1'b1);
    queue_op(abr_pkg::ACT_WRITE, 8'h5A, 1'b1);
    queue_op(abr_pkg::ACT_CLEAR, 8'h00, 1'b1);
    queue_op(abr_pkg::ACT_READ, 8'h00, 1'b1);
    drain();
    // capacity one holds nothing
    load_capacity(abr_pkg::CAP_W'(1));
    queue_op(abr_pkg::ACT_WRITE, 8'hA5, 1'b1);
    queue_op(abr_pkg::ACT_READ, 8'h00, 1'b1);
    drain();
    // disabled channel, clear still acts
    load_capacity('0);
    queue_op(abr_pkg::ACT_WRITE, 8'h3C, 1'b1);
    queue_op(abr_pkg::ACT_READ, 8'h00, 1'b1);
    queue_op(abr_pkg::ACT_CLEAR, 8'h00, 1'b0);
    drain();
    load_capacity(abr_pkg::CAP_W'(2));
    queue_op(abr_pkg::ACT_WRITE, 8'h11, 1'b0);
    queue_op(abr_pkg::ACT_WRITE, 8'h22, 1'b1);
    queue_op(abr_pkg::ACT_READ, 8'h00, 1'b1);
    drain();
    // oversized capacity saturates
    load_capacity('1);
    queue_op(abr_pkg::ACT_WRITE, 8'h80, 1'b1);
    queue_op(abr_pkg::ACT_READ, 8'h00, 1'b1);
    drain();

    foreach (phase_caps[i]) begin
      idle_pct = (i % 4 == 3) ? 0 : 10;
      load_capacity(abr_pkg::CAP_W'(phase_caps[i]));
      if (phase_caps[i] == 0) begin
        queue_traffic(40);
      end else if (i == 1) begin
        // sender holds off until the ring has answered everything
        queue_traffic(50);
        drain();
        queue_traffic(55);
      end else begin
        queue_traffic(105);
      end
      drain();
    end

    idle_pct = 0;
    load_capacity(abr_pkg::CAP_W'($urandom_range(3, 40)));
    queue_traffic(80);
    drain();
    repeat (4) @(posedge clk);

    $display("Ran %0d item transfers and %0d result transfers over %0d capacity writes",
             ops_sent, results_seen, cap_writes);
    $display("Capacities 0 to 32767; %0d overrun packets, %0d underrun requests predicted",
             overrun_events, underrun_events);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
